[sv/pcsg_pkg.sv]
// Shared types and constants of the polar curve segment generator
package pcsg_pkg;

    // curve kinds
    localparam logic [2:0] KIND_LIMACON   = 3'd0;
    localparam logic [2:0] KIND_CARDIOID  = 3'd1;
    localparam logic [2:0] KIND_ROSE3     = 3'd2;
    localparam logic [2:0] KIND_ROSE4     = 3'd3;
    localparam logic [2:0] KIND_SPIRAL    = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_CURVE_KIND    = 3'd0;
    localparam logic [2:0] CFG_RADIUS_SCALE  = 3'd1;
    localparam logic [2:0] CFG_RADIUS_OFFSET = 3'd2;
    localparam logic [2:0] CFG_CENTER_X      = 3'd3;
    localparam logic [2:0] CFG_CENTER_Y      = 3'd4;
    localparam logic [2:0] CFG_ANGLE_STEP    = 3'd5;

    // cordic constants, angles in 1/65536 turn
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [19:0] CORDIC_GAIN_Q15 = 20'sd19898;
    localparam logic [15:0] ATAN_TURN16 [CORDIC_STEPS] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1, 16'd0
    };
    localparam logic signed [15:0] TRIG_MAX = 16'sd32767;

    // 2*pi in Q13 for the spiral radius
    localparam logic [15:0] TWO_PI_Q13 = 16'd51472;

    // command to the serial multiplier
    typedef struct packed {
        logic start;
        logic neg;
    } mul_cmd_t;

    // result of one cordic pass
    typedef struct packed {
        logic               done;
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
    } trig_t;

endpackage

[sv/pcsg_cordic.sv]
// Iterative cordic: one rotation step per cycle, gives Q1.15 cos and sin
module pcsg_cordic
    import pcsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] angle,
    output trig_t       res
);

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_OUT} cstate_t;

    cstate_t            state_reg;
    logic signed [19:0] x_reg;
    logic signed [19:0] y_reg;
    logic signed [17:0] z_reg;
    logic [3:0]         i_reg;
    logic               flip_reg;

    logic [15:0]        rot;
    logic [15:0]        ang_fold;
    logic signed [19:0] sx;
    logic signed [19:0] sy;
    logic signed [17:0] at;
    logic signed [19:0] xf;
    logic signed [19:0] yf;

    // fold the angle into the right half plane
    assign rot      = angle + 16'd16384;
    assign ang_fold = rot[15] ? (angle ^ 16'h8000) : angle;

    // shifted terms of this step
    assign sx = x_reg >>> i_reg;
    assign sy = y_reg >>> i_reg;
    assign at = 18'(ATAN_TURN16[i_reg]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            i_reg     <= '0;
            flip_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= CORDIC_GAIN_Q15;
                        y_reg     <= '0;
                        z_reg     <= 18'(signed'(ang_fold));
                        i_reg     <= '0;
                        flip_reg  <= rot[15];
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    if (!z_reg[17])
                    begin
                        x_reg <= x_reg - sy;
                        y_reg <= y_reg + sx;
                        z_reg <= z_reg - at;
                    end
                    else
                    begin
                        x_reg <= x_reg + sy;
                        y_reg <= y_reg - sx;
                        z_reg <= z_reg + at;
                    end
                    i_reg <= i_reg + 4'd1;
                    if (i_reg == 4'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= C_OUT;
                    end
                end
                C_OUT:
                begin
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // undo the fold and clamp to the q15 range
    assign xf = flip_reg ? -x_reg : x_reg;
    assign yf = flip_reg ? -y_reg : y_reg;

    always_comb
    begin
        res.done = (state_reg == C_OUT);
        if (xf > 20'(TRIG_MAX))
            res.cos_v = TRIG_MAX;
        else if (xf < -20'(TRIG_MAX))
            res.cos_v = -TRIG_MAX;
        else
            res.cos_v = xf[15:0];
        if (yf > 20'(TRIG_MAX))
            res.sin_v = TRIG_MAX;
        else if (yf < -20'(TRIG_MAX))
            res.sin_v = -TRIG_MAX;
        else
            res.sin_v = yf[15:0];
    end

endmodule

[sv/pcsg_mul.sv]
// Bit-serial shift-add multiplier on magnitudes, sign applied at the end
module pcsg_mul
    import pcsg_pkg::*;
#(
    parameter int PW = 44,
    parameter int QW = 28
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mul_cmd_t             cmd,
    input  logic [PW-1:0]        mcand,
    input  logic [QW-1:0]        mplier,
    output logic                 done,
    output logic signed [PW-1:0] product
);

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX} mstate_t;

    mstate_t       state_reg;
    logic [PW-1:0] acc_reg;
    logic [PW-1:0] md_reg;
    logic [QW-1:0] mr_reg;
    logic          neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            acc_reg   <= '0;
            md_reg    <= '0;
            mr_reg    <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                M_IDLE:
                begin
                    if (cmd.start)
                    begin
                        acc_reg   <= '0;
                        md_reg    <= mcand;
                        mr_reg    <= mplier;
                        neg_reg   <= cmd.neg;
                        state_reg <= M_RUN;
                    end
                end
                M_RUN:
                begin
                    // one multiplier bit per cycle, stop at the last set bit
                    if (mr_reg == '0)
                    begin
                        state_reg <= M_FIX;
                    end
                    else
                    begin
                        if (mr_reg[0])
                            acc_reg <= acc_reg + md_reg;
                        md_reg <= {md_reg[PW-2:0], 1'b0};
                        mr_reg <= {1'b0, mr_reg[QW-1:1]};
                    end
                end
                M_FIX:
                begin
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done    = (state_reg == M_FIX);
    assign product = neg_reg ? -signed'(acc_reg) : signed'(acc_reg);

endmodule

[sv/polar_curve_segment_generator_unit.sv]
// Top level of the polar curve segment generator: config, sequencer, outputs
//
//  channel | signals                                   | accepted when
//  --------+-------------------------------------------+----------------------
//  in      | in_valid, in_stall, restart               | in_valid && !in_stall
//  out     | out_valid, out_stall, from_x .. finished  | out_valid && !out_stall
//  cfg     | cfg_we, cfg_index, cfg_data               | cfg_we
//
// A finished item skips the arithmetic. A segment takes one cordic pass (two
// for the roses) plus up to four passes of the bit-serial multiplier (two for
// the spiral radius, two for the placement), each taking one multiplier bit
// per cycle up to its top set bit.
// rst_n clears state asynchronously; curve_done comes up set.
// in_stall is high from acceptance until the result is loaded into the output
// register; a stalled output holds its item while the next one is accepted.
module polar_curve_segment_generator_unit
    import pcsg_pkg::*;
#(
    parameter int PHASE_BITS = 16,
    parameter int COORD_BITS = 13
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         restart,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] from_x,
    output logic signed [COORD_BITS-1:0] from_y,
    output logic signed [COORD_BITS-1:0] to_x,
    output logic signed [COORD_BITS-1:0] to_y,
    output logic                         last_segment,
    output logic                         finished
);

    localparam int NPW = ((PHASE_BITS > 16) ? PHASE_BITS : 16) + 2;
    localparam int RW  = 28;
    localparam int QW  = (RW > PHASE_BITS) ? RW : PHASE_BITS;
    localparam int PW  = ((PHASE_BITS + 28) > 44) ? (PHASE_BITS + 28) : 44;
    localparam int TW  = PW + 1;
    localparam int SW  = ((TW - 30) > COORD_BITS) ? (TW - 30) : (COORD_BITS + 1);
    localparam logic signed [SW-1:0] C_HI = SW'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] C_LO = -SW'(1 << (COORD_BITS - 1));
    localparam logic signed [TW-1:0] TRUNC_BIAS = TW'((64'd1 << 30) - 64'd1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_CA_GO, S_CA_WAIT, S_CB_GO, S_CB_WAIT,
        S_R1_GO, S_R1_WAIT, S_R2_GO, S_R2_WAIT, S_RADIUS,
        S_P_GO, S_P_WAIT, S_P_SUM, S_P_SAT, S_EMIT
    } state_t;

    // saturate to the coordinate range
    function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        begin
            if (v > C_HI)
                t = C_HI;
            else if (v < C_LO)
                t = C_LO;
            else
                t = v;
            return t[COORD_BITS-1:0];
        end
    endfunction

    state_t                       state_reg;
    logic [2:0]                   kind_reg;
    logic [9:0]                   a_reg;
    logic signed [10:0]           b_reg;
    logic [10:0]                  cx_reg;
    logic [10:0]                  cy_reg;
    logic [15:0]                  step_reg;
    logic [PHASE_BITS:0]          phase_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic                         curve_done_reg;
    logic [PHASE_BITS-1:0]        np_reg;
    logic                         last_reg;
    logic                         fin_reg;
    logic signed [15:0]           c_reg;
    logic signed [15:0]           s_reg;
    logic signed [15:0]           cn_reg;
    logic signed [PW-1:0]         prod_reg;
    logic signed [RW-1:0]         r_reg;
    logic                         axis_reg;
    logic signed [TW-1:0]         t_reg;
    logic signed [COORD_BITS-1:0] nx_reg;
    logic signed [COORD_BITS-1:0] ny_reg;
    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] from_x_reg;
    logic signed [COORD_BITS-1:0] from_y_reg;
    logic signed [COORD_BITS-1:0] to_x_reg;
    logic signed [COORD_BITS-1:0] to_y_reg;
    logic                         last_out_reg;
    logic                         fin_out_reg;

    logic [NPW-1:0]               np;
    logic [NPW-1:0]               np2;
    logic                         np_full;
    logic signed [SW-1:0]         start_off;
    logic [PHASE_BITS-1:0]        np_mult;
    logic [PHASE_BITS+15:0]       turn_a;
    logic [PHASE_BITS+15:0]       turn_b;
    logic [14:0]                  c_mag;
    logic [14:0]                  s_mag;
    logic [14:0]                  cn_mag;
    logic signed [RW-1:0]         r_neg;
    logic [RW-2:0]                r_mag;
    logic signed [RW-1:0]         ac;
    logic signed [RW-1:0]         r_next;
    logic [10:0]                  center;
    logic signed [TW-1:0]         t_next;
    logic signed [TW-1:0]         t_biased;
    logic                         cor_start;
    logic [15:0]                  cor_angle;
    trig_t                        cor_res;
    mul_cmd_t                     mul_cmd;
    logic [PW-1:0]                mul_mcand;
    logic [QW-1:0]                mul_mplier;
    logic                         mul_done;
    logic signed [PW-1:0]         mul_prod;
    logic                         out_free;

    // phase arithmetic
    assign np      = NPW'(phase_reg) + NPW'(step_reg);
    assign np2     = np + NPW'(step_reg);
    assign np_full = (np[NPW-1:PHASE_BITS] != '0);

    // start offset per curve kind
    always_comb
    begin
        unique case (kind_reg)
            KIND_LIMACON:  start_off = SW'(signed'({1'b0, a_reg})) + SW'(b_reg);
            KIND_CARDIOID: start_off = SW'({a_reg, 1'b0});
            KIND_ROSE3:    start_off = SW'(a_reg);
            KIND_ROSE4:    start_off = SW'(a_reg);
            default:       start_off = '0;
        endcase
    end

    // cordic angles: top 16 bits of the phase turn
    assign np_mult = (kind_reg == KIND_ROSE3) ? (np_reg + {np_reg[PHASE_BITS-2:0], 1'b0})
                                              : {np_reg[PHASE_BITS-2:0], 1'b0};
    assign turn_a  = {np_reg, 16'b0};
    assign turn_b  = {np_mult, 16'b0};

    assign cor_start = (state_reg == S_CA_GO) || (state_reg == S_CB_GO);
    assign cor_angle = (state_reg == S_CB_GO) ? turn_b[PHASE_BITS+15 -: 16]
                                              : turn_a[PHASE_BITS+15 -: 16];

    pcsg_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .angle (cor_angle),
        .res   (cor_res)
    );

    // magnitudes for the multiplier
    assign c_mag  = c_reg[15] ? 15'(-c_reg) : c_reg[14:0];
    assign s_mag  = s_reg[15] ? 15'(-s_reg) : s_reg[14:0];
    assign cn_mag = cn_reg[15] ? 15'(-cn_reg) : cn_reg[14:0];
    assign r_neg  = -r_reg;
    assign r_mag  = r_reg[RW-1] ? r_neg[RW-2:0] : r_reg[RW-2:0];

    // multiplier operands by step
    always_comb
    begin
        mul_cmd    = '0;
        mul_mcand  = '0;
        mul_mplier = '0;
        unique case (state_reg)
            S_R1_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_mcand     = PW'(a_reg);
                unique case (kind_reg)
                    KIND_SPIRAL:
                    begin
                        mul_mplier = QW'(np_reg);
                    end
                    KIND_LIMACON, KIND_CARDIOID:
                    begin
                        mul_mplier  = QW'(c_mag);
                        mul_cmd.neg = c_reg[15];
                    end
                    KIND_ROSE3, KIND_ROSE4:
                    begin
                        mul_mplier  = QW'(cn_mag);
                        mul_cmd.neg = cn_reg[15];
                    end
                    default:
                    begin
                        mul_mplier = '0;
                    end
                endcase
            end
            S_R2_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_mcand     = prod_reg;
                mul_mplier    = QW'(TWO_PI_Q13);
            end
            S_P_GO:
            begin
                mul_cmd.start = 1'b1;
                mul_mcand     = PW'(r_mag);
                mul_mplier    = axis_reg ? QW'(s_mag) : QW'(c_mag);
                mul_cmd.neg   = r_reg[RW-1] ^ (axis_reg ? s_reg[15] : c_reg[15]);
            end
            default:
            begin
                mul_cmd = '0;
            end
        endcase
    end

    pcsg_mul #(
        .PW (PW),
        .QW (QW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mul_cmd),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_prod)
    );

    // radius in q15
    assign ac = prod_reg[RW-1:0];
    always_comb
    begin
        unique case (kind_reg)
            KIND_LIMACON:  r_next = ac + (RW'(b_reg) <<< 15);
            KIND_CARDIOID: r_next = RW'({a_reg, 15'b0}) + ac;
            KIND_ROSE3:    r_next = ac;
            KIND_ROSE4:    r_next = ac;
            KIND_SPIRAL:   r_next = prod_reg[PHASE_BITS +: RW];
            default:       r_next = '0;
        endcase
    end

    // centre term plus product, then truncation toward zero
    assign center   = axis_reg ? cy_reg : cx_reg;
    assign t_next   = signed'({{(TW-41){1'b0}}, center, 30'b0}) + TW'(prod_reg);
    assign t_biased = t_reg + (t_reg[TW-1] ? TRUNC_BIAS : '0);

    assign out_free = !out_valid_reg || !out_stall;

    // sequencer, config and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            kind_reg       <= KIND_LIMACON;
            a_reg          <= 10'd175;
            b_reg          <= 11'sd60;
            cx_reg         <= 11'd200;
            cy_reg         <= 11'd250;
            step_reg       <= 16'd60;
            phase_reg      <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            curve_done_reg <= 1'b1;
            np_reg         <= '0;
            last_reg       <= 1'b0;
            fin_reg        <= 1'b0;
            c_reg          <= '0;
            s_reg          <= '0;
            cn_reg         <= '0;
            prod_reg       <= '0;
            r_reg          <= '0;
            axis_reg       <= 1'b0;
            t_reg          <= '0;
            nx_reg         <= '0;
            ny_reg         <= '0;
            out_valid_reg  <= 1'b0;
            from_x_reg     <= '0;
            from_y_reg     <= '0;
            to_x_reg       <= '0;
            to_y_reg       <= '0;
            last_out_reg   <= 1'b0;
            fin_out_reg    <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CURVE_KIND:    kind_reg <= cfg_data[2:0];
                    CFG_RADIUS_SCALE:  a_reg    <= cfg_data[9:0];
                    CFG_RADIUS_OFFSET: b_reg    <= cfg_data[10:0];
                    CFG_CENTER_X:      cx_reg   <= cfg_data[10:0];
                    CFG_CENTER_Y:      cy_reg   <= cfg_data[10:0];
                    CFG_ANGLE_STEP:    step_reg <= cfg_data;
                    default:           kind_reg <= kind_reg;
                endcase
            end

            // output item taken, the emit step reloads it itself
            if (out_valid_reg && !out_stall && state_reg != S_EMIT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (restart)
                        begin
                            curve_done_reg <= 1'b0;
                            phase_reg      <= '0;
                            prev_x_reg     <= sat_c(SW'(cx_reg) + start_off);
                            prev_y_reg     <= sat_c(SW'(cy_reg));
                        end
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    np_reg   <= np[PHASE_BITS-1:0];
                    last_reg <= (np2[NPW-1:PHASE_BITS] != '0);
                    axis_reg <= 1'b0;
                    if (curve_done_reg || np_full)
                    begin
                        curve_done_reg <= 1'b1;
                        fin_reg        <= 1'b1;
                        state_reg      <= S_EMIT;
                    end
                    else
                    begin
                        fin_reg   <= 1'b0;
                        state_reg <= S_CA_GO;
                    end
                end
                S_CA_GO:
                begin
                    state_reg <= S_CA_WAIT;
                end
                S_CA_WAIT:
                begin
                    if (cor_res.done)
                    begin
                        c_reg <= cor_res.cos_v;
                        s_reg <= cor_res.sin_v;
                        if (kind_reg == KIND_ROSE3 || kind_reg == KIND_ROSE4)
                            state_reg <= S_CB_GO;
                        else
                            state_reg <= S_R1_GO;
                    end
                end
                S_CB_GO:
                begin
                    state_reg <= S_CB_WAIT;
                end
                S_CB_WAIT:
                begin
                    if (cor_res.done)
                    begin
                        cn_reg    <= cor_res.cos_v;
                        state_reg <= S_R1_GO;
                    end
                end
                S_R1_GO:
                begin
                    state_reg <= S_R1_WAIT;
                end
                S_R1_WAIT:
                begin
                    if (mul_done)
                    begin
                        prod_reg <= mul_prod;
                        if (kind_reg == KIND_SPIRAL)
                            state_reg <= S_R2_GO;
                        else
                            state_reg <= S_RADIUS;
                    end
                end
                S_R2_GO:
                begin
                    state_reg <= S_R2_WAIT;
                end
                S_R2_WAIT:
                begin
                    if (mul_done)
                    begin
                        prod_reg  <= mul_prod;
                        state_reg <= S_RADIUS;
                    end
                end
                S_RADIUS:
                begin
                    r_reg     <= r_next;
                    state_reg <= S_P_GO;
                end
                S_P_GO:
                begin
                    state_reg <= S_P_WAIT;
                end
                S_P_WAIT:
                begin
                    if (mul_done)
                    begin
                        prod_reg  <= mul_prod;
                        state_reg <= S_P_SUM;
                    end
                end
                S_P_SUM:
                begin
                    t_reg     <= t_next;
                    state_reg <= S_P_SAT;
                end
                S_P_SAT:
                begin
                    if (axis_reg)
                    begin
                        ny_reg    <= sat_c(SW'(signed'(t_biased[TW-1:30])));
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        nx_reg    <= sat_c(SW'(signed'(t_biased[TW-1:30])));
                        axis_reg  <= 1'b1;
                        state_reg <= S_P_GO;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (fin_reg)
                        begin
                            from_x_reg   <= '0;
                            from_y_reg   <= '0;
                            to_x_reg     <= '0;
                            to_y_reg     <= '0;
                            last_out_reg <= 1'b0;
                            fin_out_reg  <= 1'b1;
                        end
                        else
                        begin
                            from_x_reg   <= prev_x_reg;
                            from_y_reg   <= prev_y_reg;
                            to_x_reg     <= nx_reg;
                            to_y_reg     <= ny_reg;
                            last_out_reg <= last_reg;
                            fin_out_reg  <= 1'b0;
                            phase_reg    <= {1'b0, np_reg};
                            prev_x_reg   <= nx_reg;
                            prev_y_reg   <= ny_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign from_x       = from_x_reg;
    assign from_y       = from_y_reg;
    assign to_x         = to_x_reg;
    assign to_y         = to_y_reg;
    assign last_segment = last_out_reg;
    assign finished     = fin_out_reg;

`ifndef SYNTHESIS
    // a finished item carries no segment
    a_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> from_x == '0 && to_x == '0 && from_y == '0
            && to_y == '0 && !last_segment)
        else $error("finished item carries segment data");

    // the stored phase stays below a full turn
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        !phase_reg[PHASE_BITS])
        else $error("phase reached a full turn");

    // only a restart clears a completed curve
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        curve_done_reg && !(in_valid && !in_stall && restart) |=> curve_done_reg)
        else $error("curve_done cleared without restart");

    // a finished item sets curve_done
    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && fin_reg |-> curve_done_reg)
        else $error("finished item without curve_done");
`endif

endmodule

[tb/tb_polar_curve_segment_generator_unit.sv]
// Testbench of the polar curve segment generator: directed and random items checked against a predictor
`timescale 1ns / 1ps

module tb_polar_curve_segment_generator_unit;
    import pcsg_pkg::*;

    localparam int PB = 16;
    localparam int CB = 13;

    typedef struct packed {
        logic signed [CB-1:0] fx;
        logic signed [CB-1:0] fy;
        logic signed [CB-1:0] tx;
        logic signed [CB-1:0] ty;
        logic                 last;
        logic                 fin;
    } segment_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic restart = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [CB-1:0] from_x, from_y, to_x, to_y;
    logic last_segment, finished;

    polar_curve_segment_generator_unit dut (.*);

    always #4 clk = ~clk;

    // predictor copy of the registers and curve state
    logic [2:0]  kind_r;
    logic [9:0]  scale_r;
    logic [10:0] offs_r;
    logic [10:0] cx_r, cy_r;
    logic [15:0] step_r;
    longint      phase_q;
    longint      pen_x, pen_y;
    bit          done_q;

    segment_t expected_segs[$];
    int errors = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp15(longint v);
        if (v > 32767) return 32767;
        if (v < -32767) return -32767;
        return v;
    endfunction

    task automatic cordic(input longint ang_in, output longint c, output longint s);
        longint ang, x, y, z, nx;
        bit flip;
        ang = ang_in & 16'hFFFF;
        flip = ((ang + 16384) & 16'hFFFF) >= 32768;
        x = 19898;
        y = 0;
        if (flip) ang = (ang + 32768) & 16'hFFFF;
        z = (ang >= 32768) ? ang - 65536 : ang;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - asr(y, i);
                y = y + asr(x, i);
                z -= longint'(ATAN_TURN16[i]);
            end
            else begin
                nx = x + asr(y, i);
                y = y - asr(x, i);
                z += longint'(ATAN_TURN16[i]);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clamp15(x);
        s = clamp15(y);
    endtask

    function automatic longint sat_coord(longint v);
        if (v > 4095) return 4095;
        if (v < -4096) return -4096;
        return v;
    endfunction

    function automatic longint place_coord(longint centre, longint r, longint t);
        longint acc;
        acc = centre * (longint'(1) << 30) + r * t;
        if (acc >= 0) return sat_coord(acc >>> 30);
        return sat_coord(-((-acc) >>> 30));
    endfunction

    function automatic longint offset_b();
        return longint'($signed(offs_r));
    endfunction

    // compute the expected segment for one item
    task automatic predict_segment(input bit rs);
        longint np, c, s, cn, sn, r, a, off;
        segment_t e;
        e = '0;
        a = scale_r;
        if (rs) begin
            done_q = 0;
            phase_q = 0;
            case (kind_r)
                KIND_LIMACON: off = a + offset_b();
                KIND_CARDIOID: off = 2 * a;
                KIND_ROSE3, KIND_ROSE4: off = a;
                default: off = 0;
            endcase
            pen_x = sat_coord(cx_r + off);
            pen_y = sat_coord(cy_r);
        end
        np = phase_q + step_r;
        if (done_q || np >= (1 << PB)) begin
            done_q = 1;
            e.fin = 1'b1;
            expected_segs.push_back(e);
            return;
        end
        cordic(np, c, s);
        case (kind_r)
            KIND_LIMACON: r = a * c + offset_b() * 32768;
            KIND_CARDIOID: r = a * 32768 + a * c;
            KIND_ROSE3: begin cordic(np * 3, cn, sn); r = a * cn; end
            KIND_ROSE4: begin cordic(np * 2, cn, sn); r = a * cn; end
            KIND_SPIRAL: r = (a * np * 51472) >> PB;
            default: r = 0;
        endcase
        e.fx = pen_x[CB-1:0];
        e.fy = pen_y[CB-1:0];
        pen_x = place_coord(cx_r, r, c);
        pen_y = place_coord(cy_r, r, s);
        e.tx = pen_x[CB-1:0];
        e.ty = pen_y[CB-1:0];
        e.last = (np + step_r >= (1 << PB));
        phase_q = np;
        expected_segs.push_back(e);
    endtask

    // send one item, with random idle cycles before it; valid drops only while idle
    task automatic send_item(input bit rs);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart <= rs;
        predict_segment(rs);
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_segs.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_CURVE_KIND: kind_r = val[2:0];
            CFG_RADIUS_SCALE: scale_r = val[9:0];
            CFG_RADIUS_OFFSET: offs_r = val[10:0];
            CFG_CENTER_X: cx_r = val[10:0];
            CFG_CENTER_Y: cy_r = val[10:0];
            CFG_ANGLE_STEP: step_r = val;
            default: ;
        endcase
    endtask

    task automatic set_curve(input logic [2:0] k, input logic [9:0] a, input logic [10:0] b,
                             input logic [10:0] x, input logic [10:0] y, input logic [15:0] st);
        drain();
        write_reg(CFG_CURVE_KIND, {13'd0, k});
        write_reg(CFG_RADIUS_SCALE, {6'd0, a});
        write_reg(CFG_RADIUS_OFFSET, {5'd0, b});
        write_reg(CFG_CENTER_X, {5'd0, x});
        write_reg(CFG_CENTER_Y, {5'd0, y});
        write_reg(CFG_ANGLE_STEP, st);
        cfg_we <= 1'b0;
    endtask

    // result checker
    always @(posedge clk) begin
        segment_t got, e;
        if (out_valid && !out_stall) begin
            got = '{from_x, from_y, to_x, to_y, last_segment, finished};
            if (expected_segs.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected segment %h", got);
            end
            else begin
                e = expected_segs.pop_front();
                if (got !== e) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d l%0b f%0b got %0d %0d %0d %0d l%0b f%0b",
                                 e.fx, e.fy, e.tx, e.ty, e.last, e.fin,
                                 got.fx, got.fy, got.tx, got.ty, got.last, got.fin);
                end
            end
        end
    end

    // receiver stall, with a long hold-off on request
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic test_reset_defaults();
        kind_r = KIND_LIMACON; scale_r = 175; offs_r = 60;
        cx_r = 200; cy_r = 250; step_r = 60;
        phase_q = 0; pen_x = 0; pen_y = 0; done_q = 1;
        send_item(1'b0);
        send_item(1'b1);
        repeat (3) send_item(1'b0);
    endtask

    task automatic test_each_kind();
        for (int k = 0; k < 8; k++) begin
            set_curve(k[2:0], 10'd300, 11'h7C0, 11'd1024, 11'd1024, 16'd5000);
            send_item(1'b1);
            repeat (2) send_item(1'b0);
        end
    endtask

    task automatic test_extremes();
        set_curve(KIND_LIMACON, 10'd1023, 11'd1023, 11'd2047, 11'd2047, 16'd30000);
        repeat (4) send_item(1'b0);
        send_item(1'b1);
        repeat (3) send_item(1'b0);
        set_curve(KIND_LIMACON, 10'd0, 11'h401, 11'd0, 11'd0, 16'd65535);
        send_item(1'b1);
        send_item(1'b0);
        set_curve(KIND_SPIRAL, 10'd1023, 11'd0, 11'd0, 11'd0, 16'd0);
        send_item(1'b1);
        send_item(1'b0);
        set_curve(KIND_CARDIOID, 10'd1023, 11'd0, 11'd2047, 11'd0, 16'd1);
        send_item(1'b1);
        send_item(1'b0);
    endtask

    task automatic test_random(input int n_items);
        int phase_sel;
        for (int i = 0; i < n_items; i++) begin
            if (i % 60 == 0) begin
                phase_sel = (i / 60) % 4;
                send_idle_pct = (phase_sel == 1 || phase_sel == 3) ? 55 : 0;
                stall_pct = (phase_sel == 2) ? 55 : (phase_sel == 3) ? 29 : 0;
                if (phase_sel == 3) send_idle_pct = 29;
                set_curve(3'($urandom_range(7)), 10'($urandom), 11'($urandom),
                          11'($urandom), 11'($urandom),
                          ($urandom_range(3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(6000, 1)));
            end
            send_item(($urandom_range(15) == 0) || (i % 60 == 0));
        end
    endtask

    task automatic test_backpressure();
        set_curve(KIND_ROSE3, 10'd500, 11'd0, 11'd1000, 11'd1000, 16'd700);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 2000;
        send_item(1'b1);
        repeat (8) send_item(1'b0);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_each_kind();
        test_extremes();
        test_backpressure();
        test_random(1200);
        drain();
        if (errors == 0 && expected_segs.size() == 0)
            $display("tb_polar_curve_segment_generator_unit: PASS");
        else
            $display("tb_polar_curve_segment_generator_unit: FAIL");
        $finish;
    end

    // run time limit
    initial begin
        #20ms;
        $display("tb_polar_curve_segment_generator_unit: FAIL");
        $finish;
    end

endmodule

[sim.f]
sv/pcsg_pkg.sv
sv/pcsg_cordic.sv
sv/pcsg_mul.sv
sv/polar_curve_segment_generator_unit.sv
tb/tb_polar_curve_segment_generator_unit.sv
